// ===== src/ptw_pkg.sv =====
// shared types, constants and helpers for the four-level page table walker
package ptw_pkg;

    // field widths
    localparam int unsigned PA_W    = 52;
    localparam int unsigned VA_W    = 64;
    localparam int unsigned SVA_W   = 48;
    localparam int unsigned ENTRY_W = 64;
    localparam int unsigned IDX_W   = 9;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned LVL_W   = 2;

    // stream packing widths, rounded up to whole bytes
    localparam int unsigned IN_DATA_W  = 184;
    localparam int unsigned OUT_DATA_W = 120;

    // action codes carried in the input tuser
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_ENTRY = 1'b1;

    // result kinds carried in the output tuser
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONCANON  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FAULT     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTPRESNT = 2'd3;

    // walk levels
    localparam logic [LVL_W-1:0] LVL_PML4 = 2'd0;
    localparam logic [LVL_W-1:0] LVL_PDPT = 2'd1;
    localparam logic [LVL_W-1:0] LVL_PD   = 2'd2;
    localparam logic [LVL_W-1:0] LVL_PT   = 2'd3;

    // entry bit positions
    localparam int unsigned PRESENT_BIT = 0;
    localparam int unsigned PS_BIT      = 7;

    // one input transaction
    typedef struct packed {
        logic                 action;
        logic [PA_W-1:0]      table_base;
        logic [VA_W-1:0]      virtual_address;
        logic [ENTRY_W-1:0]   entry_data;
        logic                 read_ok;
    } t_item;

    // one result transaction
    typedef struct packed {
        logic                 kind;
        logic [PA_W-1:0]      read_address;
        logic [ENTRY_W-1:0]   result_value;
        logic [STAT_W-1:0]    status;
    } t_result;

    // walk context kept between transactions
    typedef struct packed {
        logic                 busy;
        logic [LVL_W-1:0]     level;
        logic [SVA_W-1:0]     saved_address;
    } t_walk_state;

    // table index of the virtual address for a given level
    function automatic logic [IDX_W-1:0] level_index(input logic [SVA_W-1:0] va,
                                                     input logic [LVL_W-1:0] level);
        logic [IDX_W-1:0] idx;
        unique case (level)
            LVL_PML4: idx = va[47:39];
            LVL_PDPT: idx = va[38:30];
            LVL_PD:   idx = va[29:21];
            default:  idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

// ===== src/four_level_page_table_walker_core.sv =====
// top level of the four-level page table walker
//
// Input stream (s_axis): tuser is the action, 0 starts a translation from a
// table base and virtual address, 1 delivers a table entry read from memory
// together with its read status. Output stream (m_axis): tuser is the kind,
// 0 a read request for the 8-byte entry at read_address, 1 a finished
// translation with result_value and status. A start item always gives one
// result; an entry item gives one result while a walk is waiting and none
// otherwise.
// The input register loads when s_axis accepts a transaction, and the walk
// step fills the output register from it once that register is free; the
// output register drives m_axis. Throughput is one transaction per cycle
// while the receiver does not stall; the single combinational walk step
// between the two registers sets that figure.
// Reset clears both valid flags and the walk context, so no walk is pending.
// When the receiver stalls, the output register holds its result, the input
// register still takes one more transaction, and s_axis_tready then drops
// until the output frees up; entry items that give no result keep flowing.
module four_level_page_table_walker_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // table_base[51:0], virtual_address[115:52], entry_data[179:116],
    // read_ok[180], zero fill [183:181]
    input  logic [ptw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // action[0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // read_address[51:0], result_value[115:52], status[117:116],
    // zero fill [119:118]
    output logic [ptw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // kind[0]
    output logic                           m_axis_tuser
);
    import ptw_pkg::*;

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_result     r_out;
    t_walk_state r_state;

    logic        has_result;
    t_result     step_result;
    t_walk_state step_state;
    logic        out_free;
    logic        step_fire;

    // walk step
    ptw_step u_step (
        .i_item       (r_in),
        .i_state      (r_state),
        .o_has_result (has_result),
        .o_result     (step_result),
        .o_state      (step_state)
    );

    // handshake control
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step_fire     = r_in_valid && (out_free || !has_result);
    assign s_axis_tready = !r_in_valid || step_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.action          <= s_axis_tuser;
            r_in.table_base      <= s_axis_tdata[51:0];
            r_in.virtual_address <= s_axis_tdata[115:52];
            r_in.entry_data      <= s_axis_tdata[179:116];
            r_in.read_ok         <= s_axis_tdata[180];
        end
    end

    // walk context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (step_fire) begin
            r_state <= step_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire && has_result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (step_fire && has_result) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {2'b00, r_out.status, r_out.result_value, r_out.read_address};

endmodule

// ===== src/ptw_step.sv =====
// single-pass walk step: next request or final translation from one transaction
module ptw_step (
    input  ptw_pkg::t_item       i_item,
    input  ptw_pkg::t_walk_state i_state,
    output logic                 o_has_result,
    output ptw_pkg::t_result     o_result,
    output ptw_pkg::t_walk_state o_state
);
    import ptw_pkg::*;

    logic                 canonical;
    logic [ENTRY_W-1:0]   entry;
    logic [PA_W-1:0]      next_table;
    logic [LVL_W-1:0]     req_level;
    logic [LVL_W-1:0]     req_idx_level;
    logic [SVA_W-1:0]     req_va;
    logic [PA_W-1:0]      req_base;
    logic [PA_W-1:0]      req_addr;

    assign entry      = i_item.entry_data;
    assign canonical  = (&i_item.virtual_address[63:47]) |
                        ~(|i_item.virtual_address[63:47]);
    assign next_table = {entry[51:12], 12'h000};

    // request operands: top-level table on a start, next table on an entry
    assign req_va        = (i_item.action == ACT_START) ?
                           i_item.virtual_address[SVA_W-1:0] : i_state.saved_address;
    assign req_base      = (i_item.action == ACT_START) ? i_item.table_base : next_table;
    assign req_idx_level = (i_item.action == ACT_START) ? LVL_PML4 :
                           i_state.level + 2'd1;

    // request address: table base plus 8 times the level index, wrapping in 52 bits
    assign req_addr = req_base + {{(PA_W-IDX_W-3){1'b0}},
                                  level_index(req_va, req_idx_level), 3'b000};

    always_comb begin
        o_has_result = 1'b0;
        o_result     = '0;
        o_state      = i_state;
        req_level    = LVL_PML4;

        if (i_item.action == ACT_START) begin
            o_has_result = 1'b1;
            if (!canonical) begin
                // non-canonical address, no walk starts
                o_state.busy    = 1'b0;
                o_state.level   = LVL_PML4;
                o_result.kind   = KIND_DONE;
                o_result.status = ST_NONCANON;
            end else begin
                // new walk, drops any walk in progress
                o_state.busy          = 1'b1;
                o_state.level         = LVL_PML4;
                o_state.saved_address = i_item.virtual_address[SVA_W-1:0];
                o_result.kind         = KIND_READ;
                o_result.read_address = req_addr;
            end
        end else if (i_state.busy) begin
            o_has_result    = 1'b1;
            o_result.kind   = KIND_DONE;
            o_state.busy    = 1'b0;
            o_state.level   = LVL_PML4;
            if (!i_item.read_ok || entry == '0) begin
                o_result.status = ST_FAULT;
            end else if (!entry[PRESENT_BIT] && i_state.level == LVL_PML4) begin
                o_result.status = ST_FAULT;
            end else if (!entry[PRESENT_BIT]) begin
                // lower entry not present, handed back raw
                o_result.status       = ST_NOTPRESNT;
                o_result.result_value = entry;
            end else begin
                unique case (i_state.level)
                    LVL_PML4: begin
                        req_level = LVL_PDPT;
                    end
                    LVL_PDPT: begin
                        if (entry[PS_BIT]) begin
                            // 1 GiB page
                            o_result.result_value = {12'h000, entry[51:30],
                                                     i_state.saved_address[29:0]};
                        end else begin
                            req_level = LVL_PD;
                        end
                    end
                    LVL_PD: begin
                        if (entry[PS_BIT]) begin
                            // 2 MiB page
                            o_result.result_value = {12'h000, entry[51:21],
                                                     i_state.saved_address[20:0]};
                        end else begin
                            req_level = LVL_PT;
                        end
                    end
                    default: begin
                        // 4 KiB page
                        o_result.result_value = {12'h000, entry[51:12],
                                                 i_state.saved_address[11:0]};
                    end
                endcase
                o_result.status = ST_OK;
                // next-level read request
                if (req_level != LVL_PML4) begin
                    o_state.busy          = 1'b1;
                    o_state.level         = req_level;
                    o_result.kind         = KIND_READ;
                    o_result.read_address = req_addr;
                    o_result.result_value = '0;
                end
            end
        end
    end

endmodule

// ===== verif/four_level_page_table_walker_core_test.sv =====
// self-checking stream testbench for the four-level page table walker core
`timescale 1ns / 100ps

module four_level_page_table_walker_core_test;
    import ptw_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int CHUNK_ITEMS    = 120;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int HOLD_CYCLES    = 120;
    localparam int TIMEOUT_CYCLES = 250000;

    // frame mask for table pointers
    localparam logic [PA_W-1:0] TABLE_FRAME = 52'hF_FFFF_FFFF_F000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = ACT_START;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    // walk context mirrored from accepted transactions
    logic              model_busy  = 1'b0;
    logic [LVL_W-1:0]  model_level = LVL_PML4;
    logic [SVA_W-1:0]  model_va    = '0;

    t_result expected_walk_results[$];
    int      mismatch_count = 0;

    // stimulus shaping shared between processes
    logic tx_gap_on     = 1'b1;
    logic rx_stall_on   = 1'b1;
    int   rx_hold_cycles = 0;
    logic walk_open     = 1'b0;

    four_level_page_table_walker_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] canonical_va();
        logic [63:0] r;
        r = rand64();
        return {{16{r[47]}}, r[47:0]};
    endfunction

    // start transaction, unused fields randomized
    function automatic t_item make_start(input logic [PA_W-1:0] base,
                                         input logic [VA_W-1:0] va);
        t_item it;
        it.action          = ACT_START;
        it.table_base      = base;
        it.virtual_address = va;
        it.entry_data      = rand64();
        it.read_ok         = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // entry transaction, unused fields randomized
    function automatic t_item make_entry(input logic [ENTRY_W-1:0] entry,
                                         input logic ok);
        t_item       it;
        logic [63:0] r;
        r                  = rand64();
        it.action          = ACT_ENTRY;
        it.table_base      = r[PA_W-1:0];
        it.virtual_address = rand64();
        it.entry_data      = entry;
        it.read_ok         = ok;
        return it;
    endfunction

    // 8-byte slot of the saved address within the table of one level
    function automatic logic [PA_W-1:0] table_slot(input logic [LVL_W-1:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            LVL_PML4: idx = model_va[47:39];
            LVL_PDPT: idx = model_va[38:30];
            LVL_PD:   idx = model_va[29:21];
            default:  idx = model_va[20:12];
        endcase
        return {{(PA_W - IDX_W - 3){1'b0}}, idx, 3'b000};
    endfunction

    function automatic t_result table_read(input logic [PA_W-1:0] base,
                                           input logic [LVL_W-1:0] lvl);
        t_result r;
        r              = '0;
        model_level    = lvl;
        r.kind         = KIND_READ;
        r.read_address = base + table_slot(lvl);
        return r;
    endfunction

    function automatic t_result walk_done(input logic [ENTRY_W-1:0] value,
                                          input logic [STAT_W-1:0] st);
        t_result r;
        r              = '0;
        model_busy     = 1'b0;
        model_level    = LVL_PML4;
        r.kind         = KIND_DONE;
        r.result_value = value;
        r.status       = st;
        return r;
    endfunction

    // advance the mirrored walk by one accepted transaction
    task automatic walk_predict(input t_item it);
        t_result            r;
        logic [ENTRY_W-1:0] e;
        logic [16:0]        upper;
        e     = it.entry_data;
        upper = it.virtual_address[63:47];
        if (it.action == ACT_START) begin
            if (upper != '0 && upper != '1) begin
                r = walk_done('0, ST_NONCANON);
            end else begin
                model_busy = 1'b1;
                model_va   = it.virtual_address[SVA_W-1:0];
                r          = table_read(it.table_base, LVL_PML4);
            end
            expected_walk_results.push_back(r);
        end else if (model_busy) begin
            if (!it.read_ok || e == '0)
                r = walk_done('0, ST_FAULT);
            else if (model_level == LVL_PML4)
                r = e[PRESENT_BIT] ? table_read(e[PA_W-1:0] & TABLE_FRAME, LVL_PDPT)
                                   : walk_done('0, ST_FAULT);
            else if (!e[PRESENT_BIT])
                r = walk_done(e, ST_NOTPRESNT);
            else if (model_level == LVL_PDPT)
                r = e[PS_BIT] ? walk_done({12'b0, e[51:30], model_va[29:0]}, ST_OK)
                              : table_read(e[PA_W-1:0] & TABLE_FRAME, LVL_PD);
            else if (model_level == LVL_PD)
                r = e[PS_BIT] ? walk_done({12'b0, e[51:21], model_va[20:0]}, ST_OK)
                              : table_read(e[PA_W-1:0] & TABLE_FRAME, LVL_PT);
            else
                r = walk_done({12'b0, e[51:12], model_va[11:0]}, ST_OK);
            expected_walk_results.push_back(r);
        end
    endtask

    function automatic void note_mismatch(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
        mismatch_count++;
    endfunction

    // compare one result transaction with the oldest expectation
    task automatic check_result(input t_result got);
        t_result want;
        if (expected_walk_results.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, got);
            mismatch_count++;
            return;
        end
        want = expected_walk_results.pop_front();
        if (got.kind !== want.kind)
            note_mismatch("kind", 64'(want.kind), 64'(got.kind));
        if (got.read_address !== want.read_address)
            note_mismatch("read_address", 64'(want.read_address), 64'(got.read_address));
        if (got.result_value !== want.result_value)
            note_mismatch("result_value", want.result_value, got.result_value);
        if (got.status !== want.status)
            note_mismatch("status", 64'(want.status), 64'(got.status));
    endtask

    // watch both streams at each edge
    always @(posedge i_clk) begin : stream_monitor
        t_item   seen;
        t_result got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                seen.action          = s_axis_tuser;
                seen.table_base      = s_axis_tdata[51:0];
                seen.virtual_address = s_axis_tdata[115:52];
                seen.entry_data      = s_axis_tdata[179:116];
                seen.read_ok         = s_axis_tdata[180];
                walk_predict(seen);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind         = m_axis_tuser;
                got.read_address = m_axis_tdata[51:0];
                got.result_value = m_axis_tdata[115:52];
                got.status       = m_axis_tdata[117:116];
                check_result(got);
            end
        end
    end

    // result receiver with random stalls and an optional long hold-off
    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_cycles != 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            stall = rx_stall_on ? $urandom_range(0, 6) : 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready) && rx_hold_cycles == 0);
        end
    end

    // offer one transaction and wait for its acceptance
    task automatic send_item(input t_item it);
        int gap;
        gap = tx_gap_on ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.action;
        s_axis_tdata  <= {3'b000, it.read_ok, it.entry_data, it.virtual_address,
                          it.table_base};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering and let every pending result come out
    task automatic wait_results_drained();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_walk_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one walk with random entries, sometimes broken or abandoned
    task automatic run_walk(output int sent);
        logic [63:0] va;
        logic [63:0] base;
        logic [63:0] e;
        logic        ok;
        int          roll;
        int          lvl;
        sent = 0;
        roll = $urandom_range(0, 99);
        va   = rand64();
        base = rand64();
        if (roll < 6) begin
            if (va[63:47] == '0 || va[63:47] == '1)
                va[55] = ~va[55];
        end else begin
            va = {{16{va[47]}}, va[47:0]};
        end
        send_item(make_start(base[PA_W-1:0], va));
        sent++;
        walk_open = (roll >= 6);
        for (lvl = 0; lvl < 4 && walk_open; lvl++) begin
            roll = $urandom_range(0, 99);
            // abandoned walk, the next start drops it
            if (roll < 3)
                return;
            e              = rand64();
            e[PRESENT_BIT] = 1'b1;
            if (lvl == 1 || lvl == 2)
                e[PS_BIT] = ($urandom_range(0, 3) == 0);
            ok = 1'b1;
            if (roll < 7) begin
                ok        = 1'b0;
                walk_open = 1'b0;
            end else if (roll < 11) begin
                e         = '0;
                walk_open = 1'b0;
            end else if (roll < 16) begin
                e[PRESENT_BIT] = 1'b0;
                if (e == '0)
                    e = 64'h2;
                walk_open = 1'b0;
            end else if (lvl == 3 || ((lvl == 1 || lvl == 2) && e[PS_BIT])) begin
                walk_open = 1'b0;
            end
            send_item(make_entry(e, ok));
            sent++;
        end
    endtask

    // extremes, every outcome and every special case of the walk
    task automatic test_directed_cases();
        tx_gap_on   = 1'b1;
        rx_stall_on = 1'b1;
        // non-canonical on both sides of the hole
        send_item(make_start('0, 64'h0000_8000_0000_0000));
        send_item(make_start('1, 64'hFFFF_7FFF_FFFF_FFFF));
        // entry with no walk waiting
        send_item(make_entry(64'h1, 1'b1));
        // full four-level walk, top-level address wraps
        send_item(make_start('1, 64'hFFFF_FFFF_FFFF_FFFF));
        send_item(make_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        send_item(make_entry(64'hFFFF_FFFF_FFFF_FF7F, 1'b1));
        send_item(make_entry(64'hFFFF_FFFF_FFFF_FF7F, 1'b1));
        send_item(make_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        // 1 GiB page
        send_item(make_start('0, 64'h0000_7FFF_FFFF_FFFF));
        send_item(make_entry(64'h1, 1'b1));
        send_item(make_entry(64'h8000_0000_4000_0081, 1'b1));
        // start while busy, then a 2 MiB page
        send_item(make_start(52'h1000, 64'hFFFF_8000_0000_0000));
        send_item(make_entry(64'h3, 1'b1));
        send_item(make_start(52'h0_0000_0012_3000, 64'h0000_0000_0020_1ABC));
        send_item(make_entry(64'h0000_0000_0004_5003, 1'b1));
        send_item(make_entry(64'h0000_0000_0006_7003, 1'b1));
        send_item(make_entry(64'h0000_0000_0A00_0083, 1'b1));
        // read error
        send_item(make_start(52'h5_5000, canonical_va()));
        send_item(make_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
        // top entry not present
        send_item(make_start(52'h6_6000, canonical_va()));
        send_item(make_entry(64'h2, 1'b1));
        // zero entry below the top
        send_item(make_start(52'h7_7000, canonical_va()));
        send_item(make_entry(64'h1, 1'b1));
        send_item(make_entry(64'h0, 1'b1));
        // lower entry not present, handed back raw
        send_item(make_start(52'h8_8000, canonical_va()));
        send_item(make_entry(64'h1, 1'b1));
        send_item(make_entry(64'h8000_0000_0000_0000, 1'b1));
        wait_results_drained();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure_fill();
        int sent;
        int total;
        total          = 0;
        tx_gap_on      = 1'b0;
        rx_stall_on    = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        while (total < 30) begin
            run_walk(sent);
            total += sent;
        end
        wait_results_drained();
    endtask

    // random walks with changing idle patterns
    task automatic test_random_walks();
        int sent;
        int total;
        int chunk;
        total = 0;
        chunk = 0;
        while (total < RANDOM_ITEMS) begin
            if (chunk >= CHUNK_ITEMS) begin
                chunk = 0;
                if ($urandom_range(0, 3) == 0)
                    wait_results_drained();
                tx_gap_on   = ($urandom_range(0, 3) != 0);
                rx_stall_on = ($urandom_range(0, 3) != 0);
            end
            // stray entry with no walk waiting
            if (!walk_open && $urandom_range(0, 99) < 5)
                send_item(make_entry(rand64(), 1'($urandom_range(0, 1))));
            run_walk(sent);
            total += sent;
            chunk += sent;
        end
        wait_results_drained();
    endtask

    // test sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_backpressure_fill();
        test_random_walks();
        if (expected_walk_results.size() != 0) begin
            $display("%0t: missing results expected %h actual none (%0d pending)", $time,
                     expected_walk_results[0], expected_walk_results.size());
            mismatch_count += expected_walk_results.size();
        end
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
